// File: rtl/vpc_pkg.sv
// Shared types, coin table and change-split function for the vending payment block.
package vpc_pkg;

    localparam int NUM_COINS = 8;

    // Accepted coin values in cents, largest first (the greedy order).
    localparam logic [10:0] COIN_VALUE [NUM_COINS] = '{
        11'd1000, 11'd500, 11'd200, 11'd100, 11'd50, 11'd20, 11'd10, 11'd5
    };

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_COIN   = 2'd1,
        OP_CANCEL = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OWED    = 3'd0,
        ST_INVALID = 3'd1,
        ST_PAID    = 3'd2,
        ST_CANCEL  = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    // Classified transaction passed from front to back.
    typedef struct packed {
        t_status     status;
        logic [15:0] owed;
        logic [9:0]  rest;    // overpayment, zero unless paid
    } t_vpc_job;

    typedef struct packed {
        logic [9:0]                 given;
        logic [NUM_COINS-1:0][1:0]  cnt;
    } t_change;

    typedef struct packed {
        t_status     status;
        logic [15:0] owed;
        t_change     change;
    } t_vpc_result;

    function automatic logic coin_ok(logic [15:0] value);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_COINS; i++) begin
            if (value == {5'd0, COIN_VALUE[i]}) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Greedy split; at each denomination the remainder is below 2.5x its
    // value, so at most two coins of it are taken.
    function automatic t_change split_change(logic [9:0] rest);
        t_change res;
        logic [9:0] rem;
        res = '0;
        rem = rest;
        for (int i = 0; i < NUM_COINS; i++) begin
            if ({1'b0, rem} >= (COIN_VALUE[i] << 1)) begin
                res.cnt[i] = 2'd2;
                rem = rem - 10'(COIN_VALUE[i] << 1);
            end else if ({1'b0, rem} >= COIN_VALUE[i]) begin
                res.cnt[i] = 2'd1;
                rem = rem - COIN_VALUE[i][9:0];
            end
        end
        res.given = rest - rem;
        return res;
    endfunction

endpackage

// File: rtl/vpc_front.sv
// Front end: accepts transactions, tracks the purchase state and classifies each one.
module vpc_front import vpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_amount,
    input  logic        i_q_full,
    output logic        o_wr_en,
    output t_vpc_job    o_job
);

    logic [15:0] r_owed, n_owed;
    logic        r_active, n_active;
    logic [15:0] diff;

    assign o_wr_en = i_push && !i_q_full;
    assign diff    = i_amount - r_owed;

    always_comb begin
        n_owed       = r_owed;
        n_active     = r_active;
        o_job.status = ST_IGNORED;
        o_job.owed   = r_owed;
        o_job.rest   = '0;
        unique case (t_opcode'(i_opcode))
            OP_START: begin
                n_owed       = i_amount;
                n_active     = 1'b1;
                o_job.status = ST_OWED;
                o_job.owed   = i_amount;
            end
            OP_COIN: begin
                if (!r_active) begin
                    o_job.status = ST_IGNORED;
                end else if (!coin_ok(i_amount)) begin
                    o_job.status = ST_INVALID;
                end else if (i_amount >= r_owed) begin
                    n_owed       = '0;
                    n_active     = 1'b0;
                    o_job.status = ST_PAID;
                    o_job.owed   = '0;
                    o_job.rest   = diff[9:0];
                end else begin
                    n_owed       = r_owed - i_amount;
                    o_job.status = ST_OWED;
                    o_job.owed   = r_owed - i_amount;
                end
            end
            OP_CANCEL: begin
                if (r_active) begin
                    n_owed       = '0;
                    n_active     = 1'b0;
                    o_job.status = ST_CANCEL;
                    o_job.owed   = '0;
                end
            end
            default: begin
                o_job.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed   <= '0;
            r_active <= 1'b0;
        end else if (o_wr_en) begin
            r_owed   <= n_owed;
            r_active <= n_active;
        end
    end

endmodule

// File: rtl/vpc_queue.sv
// Two-entry queue between the front end and the change back end.
module vpc_queue import vpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr_en,
    input  t_vpc_job i_wr_job,
    input  logic     i_rd_en,
    output logic     o_full,
    output logic     o_valid,
    output t_vpc_job o_rd_job
);

    t_vpc_job   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_rd_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/vpc_back.sv
// Back end: splits the overpayment into coins and holds the result register.
module vpc_back import vpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_vpc_job    i_job,
    input  logic        i_pop,
    output logic        o_q_rd,
    output logic        o_empty,
    output t_vpc_result o_res
);

    logic        r_valid;
    t_vpc_result r_res;

    // Refill the result register when it is free or being taken this cycle.
    assign o_q_rd  = i_q_valid && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_res.status <= i_job.status;
            r_res.owed   <= i_job.owed;
            r_res.change <= split_change(i_job.rest);
        end
    end

endmodule

// File: rtl/vending_payment_and_change.sv
// Top level of the coin-payment controller with greedy change making.
// Path: a pushed transaction is written into the queue, then moved into the result register
//   once that is free or being popped; there it shows on the result ports and empty falls.
// Throughput: one transaction per cycle while pop keeps pace; full rises only when the
//   two-entry queue between the front end and the result register is occupied.
// Reset: synchronous, active low; clears the purchase state, the queue and the result valid.
module vending_payment_and_change import vpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_amount,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_owed_cents,
    output logic [9:0]  o_change_cents,
    output logic        o_count_ten_dollar,
    output logic        o_count_five_dollar,
    output logic [1:0]  o_count_two_dollar,
    output logic        o_count_one_dollar,
    output logic        o_count_fifty_cent,
    output logic [1:0]  o_count_twenty_cent,
    output logic        o_count_ten_cent,
    output logic        o_count_five_cent
);

    logic        q_full;
    logic        q_wr;
    logic        q_valid;
    logic        q_rd;
    t_vpc_job    wr_job;
    t_vpc_job    rd_job;
    t_vpc_result res;

    assign full = q_full;

    // Front end: owns the purchase state and classifies each accepted transaction.
    vpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_opcode (i_opcode),
        .i_amount (i_amount),
        .i_q_full (q_full),
        .o_wr_en  (q_wr),
        .o_job    (wr_job)
    );

    // Decouple the classifier from the result side so each can stall alone.
    vpc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (q_wr),
        .i_wr_job (wr_job),
        .i_rd_en  (q_rd),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_rd_job (rd_job)
    );

    // Back end: greedy change split, then hold the result until popped.
    vpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (rd_job),
        .i_pop     (pop),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .o_res     (res)
    );

    // Unpack the result; coin counts follow the greedy order, largest first.
    assign o_status            = res.status;
    assign o_owed_cents        = res.owed;
    assign o_change_cents      = res.change.given;
    assign o_count_ten_dollar  = res.change.cnt[0][0];
    assign o_count_five_dollar = res.change.cnt[1][0];
    assign o_count_two_dollar  = res.change.cnt[2];
    assign o_count_one_dollar  = res.change.cnt[3][0];
    assign o_count_fifty_cent  = res.change.cnt[4][0];
    assign o_count_twenty_cent = res.change.cnt[5];
    assign o_count_ten_cent    = res.change.cnt[6][0];
    assign o_count_five_cent   = res.change.cnt[7][0];

endmodule

// File: sim/vpc_checker.sv
// Checker for the vending payment block: predicts each result and compares it field by field.
`timescale 1ns / 1ps
module vpc_checker import vpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_amount,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_owed_cents,
    input  logic [9:0]  i_change_cents,
    input  logic        i_count_ten_dollar,
    input  logic        i_count_five_dollar,
    input  logic [1:0]  i_count_two_dollar,
    input  logic        i_count_one_dollar,
    input  logic        i_count_fifty_cent,
    input  logic [1:0]  i_count_twenty_cent,
    input  logic        i_count_ten_cent,
    input  logic        i_count_five_cent,
    output int          o_fail_count,
    output int          o_pending
);

    // One predicted result; coins[i] counts the denomination COIN_VALUE[i].
    typedef struct packed {
        t_status                    status;
        logic [15:0]                owed;
        logic [9:0]                 change;
        logic [NUM_COINS-1:0][1:0]  coins;
    } t_payout;

    t_payout     payouts_due[$];
    logic [15:0] owed_left;
    logic        armed;
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic logic accepted_coin(input logic [15:0] value);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_COINS; i++) begin
            if (int'(value) == int'(COIN_VALUE[i])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Greedy change by division, largest denomination first; drop any residue.
    function automatic t_payout settle(input int over);
        t_payout p;
        int      rest;
        int      given;
        int      n;
        p      = '0;
        rest   = over;
        given  = 0;
        for (int i = 0; i < NUM_COINS; i++) begin
            n          = rest / int'(COIN_VALUE[i]);
            rest       = rest - n * int'(COIN_VALUE[i]);
            given      = given + n * int'(COIN_VALUE[i]);
            p.coins[i] = n[1:0];
        end
        p.status = ST_PAID;
        p.owed   = '0;
        p.change = given[9:0];
        return p;
    endfunction

    task automatic predict(input logic [1:0] op, input logic [15:0] amt);
        t_payout p;
        p        = '0;
        p.status = ST_IGNORED;
        p.owed   = owed_left;
        case (op)
            OP_START: begin
                owed_left = amt;
                armed     = 1'b1;
                p.status  = ST_OWED;
                p.owed    = amt;
            end
            OP_COIN: begin
                if (armed) begin
                    if (!accepted_coin(amt)) begin
                        p.status = ST_INVALID;
                    end else if (amt >= owed_left) begin
                        p         = settle(int'(amt) - int'(owed_left));
                        owed_left = '0;
                        armed     = 1'b0;
                    end else begin
                        owed_left = owed_left - amt;
                        p.status  = ST_OWED;
                        p.owed    = owed_left;
                    end
                end
            end
            OP_CANCEL: begin
                if (armed) begin
                    owed_left = '0;
                    armed     = 1'b0;
                    p.status  = ST_CANCEL;
                    p.owed    = '0;
                end
            end
            default: begin
            end
        endcase
        payouts_due.push_back(p);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_payout want;
        if (payouts_due.size() == 0) begin
            $error("status: expected no transaction, actual %0d", i_status);
            fails++;
        end else begin
            want = payouts_due.pop_front();
            compare_field("status", want.status, i_status);
            compare_field("owed_cents", want.owed, i_owed_cents);
            compare_field("change_cents", want.change, i_change_cents);
            compare_field("count_ten_dollar", want.coins[0], {1'b0, i_count_ten_dollar});
            compare_field("count_five_dollar", want.coins[1], {1'b0, i_count_five_dollar});
            compare_field("count_two_dollar", want.coins[2], i_count_two_dollar);
            compare_field("count_one_dollar", want.coins[3], {1'b0, i_count_one_dollar});
            compare_field("count_fifty_cent", want.coins[4], {1'b0, i_count_fifty_cent});
            compare_field("count_twenty_cent", want.coins[5], i_count_twenty_cent);
            compare_field("count_ten_cent", want.coins[6], {1'b0, i_count_ten_cent});
            compare_field("count_five_cent", want.coins[7], {1'b0, i_count_five_cent});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            owed_left = '0;
            armed     = 1'b0;
            payouts_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_result();
            end
            if (i_push && !i_full) begin
                predict(i_opcode, i_amount);
            end
        end
        o_pending = payouts_due.size();
    end

endmodule

// File: sim/vending_payment_and_change_tb.sv
// Testbench top for the vending payment block: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module vending_payment_and_change_tb import vpc_pkg::*;;

    // Opcode the block leaves unused; it must be ignored.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int ITEMS        = 1450;
    localparam int STALL_CYCLES = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_opcode;
    logic [15:0] i_amount;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic [15:0] o_owed_cents;
    logic [9:0]  o_change_cents;
    logic        o_count_ten_dollar;
    logic        o_count_five_dollar;
    logic [1:0]  o_count_two_dollar;
    logic        o_count_one_dollar;
    logic        o_count_fifty_cent;
    logic [1:0]  o_count_twenty_cent;
    logic        o_count_ten_cent;
    logic        o_count_five_cent;

    int fail_count;
    int pending;

    // Shared between the sender and the receiver process.
    bit no_idle   = 1'b0;   // both sides run flat out while set
    bit stall_req = 1'b0;   // receiver holds pop low for STALL_CYCLES, then clears it

    // Stimulus bookkeeping; the sender tracks the owed amount only to shape sequences.
    int          served;
    int          left;
    int          steps;
    int          roll;
    bit          done;
    logic [15:0] price;
    logic [15:0] coin;
    int          cycles;

    vending_payment_and_change dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_opcode            (i_opcode),
        .i_amount            (i_amount),
        .empty               (empty),
        .pop                 (pop),
        .o_status            (o_status),
        .o_owed_cents        (o_owed_cents),
        .o_change_cents      (o_change_cents),
        .o_count_ten_dollar  (o_count_ten_dollar),
        .o_count_five_dollar (o_count_five_dollar),
        .o_count_two_dollar  (o_count_two_dollar),
        .o_count_one_dollar  (o_count_one_dollar),
        .o_count_fifty_cent  (o_count_fifty_cent),
        .o_count_twenty_cent (o_count_twenty_cent),
        .o_count_ten_cent    (o_count_ten_cent),
        .o_count_five_cent   (o_count_five_cent)
    );

    vpc_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_full              (full),
        .i_opcode            (i_opcode),
        .i_amount            (i_amount),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_status            (o_status),
        .i_owed_cents        (o_owed_cents),
        .i_change_cents      (o_change_cents),
        .i_count_ten_dollar  (o_count_ten_dollar),
        .i_count_five_dollar (o_count_five_dollar),
        .i_count_two_dollar  (o_count_two_dollar),
        .i_count_one_dollar  (o_count_one_dollar),
        .i_count_fifty_cent  (o_count_fifty_cent),
        .i_count_twenty_cent (o_count_twenty_cent),
        .i_count_ten_cent    (o_count_ten_cent),
        .i_count_five_cent   (o_count_five_cent),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // 8 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the handshakes never finish.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one transaction, called at a falling edge. Idle at random first, with
    // scrambled data on the bus, then hold push until an edge where full is low.
    // Return at the next falling edge so that push changes there and nowhere else.
    task automatic push_item(input logic [1:0] op, input logic [15:0] amt);
        while (!no_idle && $urandom_range(0, 99) < 34) begin
            push     <= 1'b0;
            i_opcode <= 2'($urandom);
            i_amount <= 16'($urandom);
            @(negedge i_clk);
        end
        push     <= 1'b1;
        i_opcode <= op;
        i_amount <= amt;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A coin value the block must reject: a near miss of a real coin, zero, or a
    // value above the largest coin.
    function automatic logic [15:0] bad_coin();
        logic [15:0] v;
        case ($urandom_range(0, 2))
            0:       v = 16'(COIN_VALUE[$urandom_range(0, NUM_COINS - 1)])
                         + 16'($urandom_range(1, 4));
            1:       v = 16'd0;
            default: v = 16'($urandom_range(1001, 65535));
        endcase
        return v;
    endfunction

    // Receiver: pop at random, with a long hold-off on request so that the
    // block's queue fills and full backs up the sender.
    initial begin
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                pop <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial begin
        push     = 1'b0;
        i_opcode = OP_START;
        i_amount = '0;
        i_rst_n  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: idle handling first, while no purchase is armed.
        push_item(OP_COIN, 16'd100);            // valid coin while idle
        push_item(OP_COIN, 16'd7);              // invalid coin while idle
        push_item(OP_CANCEL, 16'hFFFF);         // cancel while idle
        push_item(OP_SPARE, 16'hFFFF);          // unused opcode while idle
        // Largest price, reject a bad coin, then restart mid-purchase.
        push_item(OP_START, 16'hFFFF);
        push_item(OP_COIN, 16'd3);
        push_item(OP_COIN, 16'd1000);
        push_item(OP_START, 16'd385);
        push_item(OP_SPARE, 16'h0000);          // unused opcode during a purchase
        push_item(OP_COIN, 16'd5);
        push_item(OP_COIN, 16'd1000);           // overpay: 620 in change
        // Zero price: the next coin comes back whole.
        push_item(OP_START, 16'd0);
        push_item(OP_COIN, 16'd1000);
        // Exact payment.
        push_item(OP_START, 16'd300);
        push_item(OP_COIN, 16'd200);
        push_item(OP_COIN, 16'd100);
        // Residue below five cents gets dropped.
        push_item(OP_START, 16'd3);
        push_item(OP_COIN, 16'd5);
        push_item(OP_START, 16'd1);
        push_item(OP_COIN, 16'd1000);           // 999 over: both double counts, 4 cents dropped
        // Zero-valued coin, cancel a live purchase, then pay in halves.
        push_item(OP_START, 16'd250);
        push_item(OP_COIN, 16'd0);
        push_item(OP_CANCEL, 16'd0);
        push_item(OP_START, 16'd100);
        push_item(OP_COIN, 16'd50);
        push_item(OP_COIN, 16'd50);

        // Random part: mostly complete purchases with random content, some noise.
        // Kick off the receiver hold-off right away while the sender keeps going.
        stall_req = 1'b1;
        served    = 0;
        while (served < ITEMS) begin
            no_idle = (served >= 500 && served < 800);
            if ($urandom_range(0, 99) < 85) begin
                price = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2500));
                push_item(OP_START, price);
                served++;
                left  = int'(price);
                steps = 0;
                done  = 1'b0;
                while (!done) begin
                    roll = $urandom_range(0, 99);
                    if (steps >= 10 || roll < 4) begin
                        push_item(OP_CANCEL, 16'($urandom));
                        done = 1'b1;
                    end else if (roll < 8) begin
                        price = 16'($urandom_range(0, 2500));
                        push_item(OP_START, price);
                        left = int'(price);
                    end else if (roll < 20) begin
                        push_item(OP_COIN, bad_coin());
                    end else begin
                        coin = 16'(COIN_VALUE[$urandom_range(0, NUM_COINS - 1)]);
                        push_item(OP_COIN, coin);
                        if (int'(coin) >= left) begin
                            done = 1'b1;
                        end else begin
                            left = left - int'(coin);
                        end
                    end
                    served++;
                    steps++;
                end
            end else begin
                // Noise between purchases; the block ignores all of it.
                case ($urandom_range(0, 2))
                    0:       push_item(OP_SPARE, 16'($urandom));
                    1:       push_item(OP_COIN, ($urandom_range(0, 1) == 0)
                                 ? 16'(COIN_VALUE[$urandom_range(0, NUM_COINS - 1)])
                                 : 16'($urandom));
                    default: push_item(OP_CANCEL, 16'($urandom));
                endcase
                served++;
            end
        end
        no_idle = 1'b0;
        push <= 1'b0;

        // Drain, then give any stray transaction time to show up.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/vpc_pkg.sv
rtl/vpc_front.sv
rtl/vpc_queue.sv
rtl/vpc_back.sv
rtl/vending_payment_and_change.sv
sim/vpc_checker.sv
sim/vending_payment_and_change_tb.sv
